/* hdl/rar_pkg.sv */
// rar_pkg: shared types and constants for rational_arith_reduce.
// No dependencies.
`timescale 1ns / 1ps
package rar_pkg;
  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;
  localparam int REQ_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_NORM = 3'd0,
    REQ_ADD  = 3'd1,
    REQ_SUB  = 3'd2,
    REQ_MUL  = 3'd3,
    REQ_DIV  = 3'd4
  } req_t;
endpackage

/* hdl/rar_gcd.sv */
// rar_gcd: reduces a signed-magnitude fraction by its gcd (binary gcd, one step per cycle),
// then divides both parts by the gcd with restoring division. Uses rar_pkg.
`timescale 1ns / 1ps
module rar_gcd #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         neg_in,
  input  logic [W-1:0] n_in,
  input  logic [W-1:0] d_in,
  output logic         busy,
  output logic         done,
  output logic         neg_out,
  output logic [W-1:0] n_out,
  output logic [W-1:0] d_out
);
  import rar_pkg::*;

  localparam int CW = $clog2(W + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GCD  = 5'b00010,
    S_DIVN = 5'b00100,
    S_DIVD = 5'b01000,
    S_DONE = 5'b10000
  } st_t;

  st_t st;
  logic [W-1:0] u, v, nreg, dreg, dvsr, quo, rem;
  logic [CW-1:0] sh, cnt;
  logic [W:0] trial;
  logic [W-1:0] dif;

  assign busy = (st != S_IDLE);
  assign done = (st == S_DONE);
  assign trial = {rem, quo[W-1]} - {1'b0, dvsr};
  assign dif = (u > v) ? u - v : v - u;

  // Run binary gcd, then two serial divides; a zero part goes straight to done
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      case (st)
        S_IDLE: begin
          if (start) begin
            nreg <= n_in;
            dreg <= d_in;
            if (n_in == '0) begin
              neg_out <= 1'b0; n_out <= W'(1'b0); d_out <= W'(1'b1); st <= S_DONE;
            end else if (d_in == '0) begin
              neg_out <= 1'b0; n_out <= W'(1'b1); d_out <= '0; st <= S_DONE;
            end else begin
              neg_out <= neg_in;
              u <= n_in; v <= d_in; sh <= '0; st <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (u == v) begin
            dvsr <= u << sh;
            quo <= nreg; rem <= '0; cnt <= '0; st <= S_DIVN;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1; v <= v >> 1; sh <= sh + 1'b1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u > v) begin
            u <= dif >> 1;
          end else begin
            v <= dif >> 1;
          end
        end
        S_DIVN, S_DIVD: begin
          if (cnt == CW'(W - 1)) begin
            // Last quotient bit: store the quotient and move on
            cnt <= '0;
            rem <= '0;
            if (st == S_DIVN) begin
              n_out <= {quo[W-2:0], !trial[W]};
              quo <= dreg; st <= S_DIVD;
            end else begin
              d_out <= {quo[W-2:0], !trial[W]};
              st <= S_DONE;
            end
          end else begin
            cnt <= cnt + 1'b1;
            if (!trial[W]) begin
              rem <= trial[W-1:0]; quo <= {quo[W-2:0], 1'b1};
            end else begin
              rem <= {rem[W-2:0], quo[W-1]}; quo <= {quo[W-2:0], 1'b0};
            end
          end
        end
        S_DONE: st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

/* hdl/rar_front.sv */
// rar_front: accepts requests, reduces both operands and forms the products for the request type.
// Uses rar_pkg and rar_gcd.
`timescale 1ns / 1ps
module rar_front #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rar_pkg::REQ_W-1:0]  req_type,
  input  logic [OPERAND_WIDTH-1:0]   a_num,
  input  logic [OPERAND_WIDTH-1:0]   a_den,
  input  logic [OPERAND_WIDTH-1:0]   b_num,
  input  logic [OPERAND_WIDTH-1:0]   b_den,
  output logic                       q_valid,
  input  logic                       q_ready,
  output logic                       q_neg,
  output logic [2*OPERAND_WIDTH:0]   q_num,
  output logic [2*OPERAND_WIDTH-1:0] q_den
);
  import rar_pkg::*;

  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_RA   = 5'b00010,
    F_RB   = 5'b00100,
    F_MUL  = 5'b01000,
    F_OUT  = 5'b10000
  } fst_t;

  fst_t st;
  logic [REQ_W-1:0] op;
  logic [OW-1:0] rbn, rbd;
  logic an, bn;
  logic [OW-1:0] anm, adm, bnm, bdm;
  logic g_start, g_busy, g_done, g_neg;
  logic [OW-1:0] g_n, g_d, g_nin, g_din;
  logic g_negin;
  logic [OW-1:0] rn_mag, rd_mag;

  function automatic logic [OW-1:0] mag(input logic [OW-1:0] x);
    return x[OW-1] ? (~x + 1'b1) : x;
  endfunction

  assign in_ready = (st == F_IDLE);
  assign q_valid  = (st == F_OUT);

  rar_gcd #(.W(OW)) u_gcd (
    .clk(clk), .rst(rst), .start(g_start), .neg_in(g_negin), .n_in(g_nin), .d_in(g_din),
    .busy(g_busy), .done(g_done), .neg_out(g_neg), .n_out(g_n), .d_out(g_d)
  );

  assign rn_mag = mag(rbn);
  assign rd_mag = mag(rbd);
  assign g_nin = rn_mag;
  assign g_din = rd_mag;
  assign g_negin = rbn[OW-1] ^ rbd[OW-1];
  assign g_start = (st == F_RA || st == F_RB) && !g_busy && !g_done;

  // Sequence operand reductions, then the result products
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
    end else begin
      case (st)
        F_IDLE: begin
          if (in_valid) begin
            op <= req_type; rbn <= a_num; rbd <= a_den; bnm <= b_num; bdm <= b_den;
            st <= F_RA;
          end
        end
        F_RA: begin
          if (g_done) begin
            an <= g_neg; anm <= g_n; adm <= g_d;
            rbn <= bnm; rbd <= bdm;
            st <= F_RB;
          end
        end
        F_RB: begin
          if (g_done) begin
            bn <= g_neg; bnm <= g_n; bdm <= g_d;
            st <= F_MUL;
          end
        end
        F_MUL: begin
          // products registered one per arm
          case (op)
            REQ_ADD, REQ_SUB: begin
              logic [PW-1:0] p1, p2;
              logic s2;
              p1 = PW'(anm) * PW'(bdm);
              p2 = PW'(bnm) * PW'(adm);
              s2 = (op == REQ_SUB) ? !bn : bn;
              q_den <= PW'(adm) * PW'(bdm);
              if (an == s2) begin
                q_neg <= an; q_num <= {1'b0, p1} + {1'b0, p2};
              end else if (p1 >= p2) begin
                q_neg <= an; q_num <= {1'b0, p1 - p2};
              end else begin
                q_neg <= s2; q_num <= {1'b0, p2 - p1};
              end
            end
            REQ_MUL: begin
              q_neg <= an ^ bn; q_num <= {1'b0, PW'(anm) * PW'(bnm)};
              q_den <= PW'(adm) * PW'(bdm);
            end
            REQ_DIV: begin
              q_neg <= an ^ bn; q_num <= {1'b0, PW'(anm) * PW'(bdm)};
              q_den <= PW'(adm) * PW'(bnm);
            end
            default: begin
              q_neg <= an; q_num <= (PW + 1)'(anm); q_den <= PW'(adm);
            end
          endcase
          st <= F_OUT;
        end
        F_OUT: if (q_ready) st <= F_IDLE;
        default: st <= F_IDLE;
      endcase
    end
  end
endmodule

/* hdl/rar_back.sv */
// rar_back: reduces the combined fraction and holds the result for transfer.
// Uses rar_pkg and rar_gcd.
`timescale 1ns / 1ps
module rar_back #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  logic                       q_neg,
  input  logic [2*OPERAND_WIDTH:0]   q_num,
  input  logic [2*OPERAND_WIDTH-1:0] q_den,
  output logic                       o_valid,
  input  logic                       o_ready,
  output logic [rar_pkg::NUM_W-1:0]  o_num,
  output logic [rar_pkg::DEN_W-1:0]  o_den
);
  import rar_pkg::*;

  localparam int GW = 2 * OPERAND_WIDTH + 1;

  logic g_start, g_busy, g_done, g_neg;
  logic [GW-1:0] g_n, g_d, sn;
  logic [NUM_W-1:0] num_t;

  assign q_ready = !g_busy && !o_valid;
  assign g_start = q_valid && q_ready;

  rar_gcd #(.W(GW)) u_gcd (
    .clk(clk), .rst(rst), .start(g_start), .neg_in(q_neg), .n_in(q_num),
    .d_in({1'b0, q_den}), .busy(g_busy), .done(g_done), .neg_out(g_neg),
    .n_out(g_n), .d_out(g_d)
  );

  assign sn = g_neg ? (~g_n + 1'b1) : g_n;
  assign num_t = NUM_W'($signed(sn));

  // Hold the result until transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (g_done) begin
      o_valid <= 1'b1;
      o_num <= num_t;
      o_den <= DEN_W'(g_d);
    end else if (o_ready) begin
      o_valid <= 1'b0;
    end
  end
endmodule

/* hdl/rational_arith_reduce.sv */
// rational_arith_reduce: top level of the fraction arithmetic unit.
// Uses rar_pkg, rar_front, rar_back.
//
//  channel | direction | tdata fields (low bit up)
//  s_axis  | in        | a_num, a_den, b_num, b_den ; tuser = req_type
//  m_axis  | out       | res_num[32:0], res_den[30:0]
//
// One gcd pass runs the binary gcd steps, then two serial restoring divides.
// The front runs two W-bit passes, the back one 2W+1-bit pass; zero parts skip
// their passes.
// Front and back overlap, joined by one-entry hand-off register.
// rst is synchronous; it clears all control state. A stalled m_axis holds its data.
`timescale 1ns / 1ps
module rational_arith_reduce #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
  input  logic [rar_pkg::REQ_W-1:0] s_axis_tuser,              // req_type
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [63:0]              m_axis_tdata                // res_num, res_den
);
  import rar_pkg::*;

  localparam int OW = OPERAND_WIDTH;

  logic q_valid, q_ready, q_neg;
  logic [2*OW:0] q_num;
  logic [2*OW-1:0] q_den;
  logic [NUM_W-1:0] o_num;
  logic [DEN_W-1:0] o_den;

  rar_front #(.OPERAND_WIDTH(OW)) u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .req_type(s_axis_tuser),
    .a_num(s_axis_tdata[OW-1:0]), .a_den(s_axis_tdata[2*OW-1:OW]),
    .b_num(s_axis_tdata[3*OW-1:2*OW]), .b_den(s_axis_tdata[4*OW-1:3*OW]),
    .q_valid(q_valid), .q_ready(q_ready), .q_neg(q_neg), .q_num(q_num), .q_den(q_den)
  );

  rar_back #(.OPERAND_WIDTH(OW)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_neg(q_neg),
    .q_num(q_num), .q_den(q_den), .o_valid(m_axis_tvalid), .o_ready(m_axis_tready),
    .o_num(o_num), .o_den(o_den)
  );

  assign m_axis_tdata = {o_den, o_num};
endmodule
